// ===== rtl/uart_ring_buffers_rts_cts_flow_defines.svh =====
// Assertion macros shared by the ring buffer block.
// Each assumes a clock named clk and an active-low reset named rst_n in scope.
`ifndef UART_RING_BUFFERS_RTS_CTS_FLOW_DEFINES_SVH
`define UART_RING_BUFFERS_RTS_CTS_FLOW_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define URB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("urb assertion failed");

`define URB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urb assertion failed");

`else

`define URB_ASSERT(label, prop)

`define URB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/urb_pkg.sv =====
`timescale 1ns / 1ps

package urb_pkg;

    localparam int CFG_W        = 12;
    localparam int RX_DEPTH_DEF = 2048;
    localparam int TX_DEPTH_DEF = 2048;
    localparam int MIN_RING     = 128;
    localparam int NUM_ERR      = 4;
    localparam int ERR_W        = 32;

    // line status bit positions
    localparam int LS_RX_READY = 0;
    localparam int LS_OVERRUN  = 1;
    localparam int LS_PARITY   = 2;
    localparam int LS_FRAMING  = 3;
    localparam int LS_TX_READY = 5;

    // error counter slots
    localparam logic [1:0] ERR_OVERRUN = 2'd0;
    localparam logic [1:0] ERR_PARITY  = 2'd1;
    localparam logic [1:0] ERR_FRAMING = 2'd2;
    localparam logic [1:0] ERR_MISSED  = 2'd3;

    // configuration reset values
    localparam logic [1:0]       DWS_RESET       = 2'd3;
    localparam logic             FLOW_RESET      = 1'b1;
    localparam logic [CFG_W-1:0] THR_RESET       = 12'd32;
    localparam logic [CFG_W-1:0] RING_SIZE_RESET = 12'd2048;

    typedef enum logic [2:0] {
        CMD_UART_EVENT  = 3'd0,
        CMD_HOST_WRITE  = 3'd1,
        CMD_HOST_READ   = 3'd2,
        CMD_FLUSH_RX    = 3'd3,
        CMD_FLUSH_TX    = 3'd4,
        CMD_READ_ERRORS = 3'd5
    } urb_cmd_t;

    typedef enum logic [2:0] {
        REG_DATA_WIDTH_SEL    = 3'd0,
        REG_FLOW_ENABLE       = 3'd1,
        REG_RTS_OFF_THRESHOLD = 3'd2,
        REG_RX_RING_SIZE      = 3'd3,
        REG_TX_RING_SIZE      = 3'd4
    } urb_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } urb_state_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] line_status;
        logic [7:0] rx_byte;
        logic       cts;
        logic       dsr;
        logic [7:0] host_byte;
    } urb_item_t;

    typedef struct packed {
        logic [7:0]       rx_data;
        logic             rx_data_valid;
        logic [7:0]       tx_data;
        logic             tx_data_valid;
        logic             write_accepted;
        logic             rts_level;
        logic [11:0]      rx_fill;
        logic             tx_idle;
        logic [1:0]       irq_enables;
        logic [1:0]       error_kind;
        logic [ERR_W-1:0] error_count;
        logic             last;
    } urb_result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic res_taken;
    } urb_ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last_res;
    } urb_ctrl_sts_t;

    function automatic logic [7:0] char_mask(input logic [1:0] sel);
        logic [7:0] m;
        unique case (sel)
            2'd0: m = 8'h1F;
            2'd1: m = 8'h3F;
            2'd2: m = 8'h7F;
            2'd3: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/urb_item_if.sv =====
`timescale 1ns / 1ps

interface urb_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] line_status;
    logic [7:0] rx_byte;
    logic       cts;
    logic       dsr;
    logic [7:0] host_byte;

    modport source (
        output valid, command, line_status, rx_byte, cts, dsr, host_byte,
        input  ready
    );
    modport sink (
        input  valid, command, line_status, rx_byte, cts, dsr, host_byte,
        output ready
    );
endinterface

// ===== rtl/urb_result_if.sv =====
`timescale 1ns / 1ps

interface urb_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_data;
    logic        rx_data_valid;
    logic [7:0]  tx_data;
    logic        tx_data_valid;
    logic        write_accepted;
    logic        rts_level;
    logic [11:0] rx_fill;
    logic        tx_idle;
    logic [1:0]  irq_enables;
    logic [1:0]  error_kind;
    logic [31:0] error_count;
    logic        last;

    modport source (
        output valid, rx_data, rx_data_valid, tx_data, tx_data_valid, write_accepted,
               rts_level, rx_fill, tx_idle, irq_enables, error_kind, error_count, last,
        input  ready
    );
    modport sink (
        input  valid, rx_data, rx_data_valid, tx_data, tx_data_valid, write_accepted,
               rts_level, rx_fill, tx_idle, irq_enables, error_kind, error_count, last,
        output ready
    );
endinterface

// ===== rtl/urb_cfg_if.sv =====
`timescale 1ns / 1ps

interface urb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/urb_ctrl.sv =====
`timescale 1ns / 1ps

module urb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  urb_pkg::urb_ctrl_sts_t ctrl_sts,
    output urb_pkg::urb_ctrl_cmd_t ctrl_cmd
);

    urb_pkg::urb_state_t state_reg;
    urb_pkg::urb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= urb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            urb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = urb_pkg::ST_EXEC;
                end
            end
            urb_pkg::ST_EXEC:
            begin
                state_next = urb_pkg::ST_RESP;
            end
            urb_pkg::ST_RESP:
            begin
                // read-errors stays here for all four counters
                if (out_ready && ctrl_sts.last_res)
                begin
                    state_next = urb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = urb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready           = (state_reg == urb_pkg::ST_IDLE);
        out_valid          = (state_reg == urb_pkg::ST_RESP);
        ctrl_cmd.load      = in_ready && in_valid;
        ctrl_cmd.exec      = (state_reg == urb_pkg::ST_EXEC);
        ctrl_cmd.res_taken = out_valid && out_ready;
    end

endmodule

// ===== rtl/urb_datapath.sv =====
`timescale 1ns / 1ps

module urb_datapath #(
    parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = urb_pkg::TX_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  urb_pkg::urb_ctrl_cmd_t     ctrl_cmd,
    output urb_pkg::urb_ctrl_sts_t     ctrl_sts,
    input  urb_pkg::urb_item_t         item,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [urb_pkg::CFG_W-1:0]  cfg_data,
    output urb_pkg::urb_result_t       result
);

    localparam int CW    = urb_pkg::CFG_W;
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int RX_LW = $clog2(RX_DEPTH + 1);
    localparam int RX_CW = (RX_LW > CW) ? RX_LW : CW;
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_LW = $clog2(TX_DEPTH + 1);
    localparam int TX_CW = (TX_LW > CW) ? TX_LW : CW;
    localparam int EW    = urb_pkg::ERR_W;

    // ring stores, no reset
    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];
    logic [7:0] rx_rd_reg;
    logic [7:0] tx_rd_reg;

    urb_pkg::urb_item_t item_reg;

    logic [1:0]    dws_reg,  dws_next;
    logic          flow_reg, flow_next;
    logic [CW-1:0] thr_reg,  thr_next;
    logic [CW-1:0] rx_size_reg, rx_size_next;
    logic [CW-1:0] tx_size_reg, tx_size_next;

    logic [RX_AW-1:0] rx_head_reg, rx_head_next;
    logic [RX_AW-1:0] rx_tail_reg, rx_tail_next;
    logic [RX_LW-1:0] rx_level_reg, rx_level_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next;
    logic [TX_AW-1:0] tx_tail_reg, tx_tail_next;

    logic rts_reg,  rts_next;
    logic tbre_reg, tbre_next;
    logic msr_reg,  msr_next;

    logic [EW-1:0] err_cnt_reg  [urb_pkg::NUM_ERR];
    logic [EW-1:0] err_cnt_next [urb_pkg::NUM_ERR];
    logic [1:0]    k_reg, k_next;

    logic rx_valid_reg, rx_valid_next;
    logic tx_valid_reg, tx_valid_next;
    logic wa_reg, wa_next;

    logic       rx_we, tx_we;
    logic [7:0] rx_wdata;

    // effective ring sizes and pointer arithmetic
    logic [RX_CW-1:0] rx_sz_req, rx_sz_sat;
    logic [TX_CW-1:0] tx_sz_req, tx_sz_sat;
    logic [RX_LW-1:0] rx_sz, rx_head_inc, rx_tail_inc, rx_free, rx_free_up;
    logic [TX_LW-1:0] tx_sz, tx_head_inc, tx_tail_inc;
    logic [RX_AW-1:0] rx_nh, rx_nt;
    logic [TX_AW-1:0] tx_nh, tx_nt;
    logic             rx_full, tx_full, tx_empty, rx_has_data;
    logic             rts_drop, rts_raise, tx_allowed, dump;

    always_comb
    begin
        rx_sz_req = RX_CW'(rx_size_reg);
        if (rx_sz_req < RX_CW'(urb_pkg::MIN_RING))
            rx_sz_sat = RX_CW'(urb_pkg::MIN_RING);
        else if (rx_sz_req > RX_CW'(RX_DEPTH))
            rx_sz_sat = RX_CW'(RX_DEPTH);
        else
            rx_sz_sat = rx_sz_req;
        rx_sz = RX_LW'(rx_sz_sat);

        tx_sz_req = TX_CW'(tx_size_reg);
        if (tx_sz_req < TX_CW'(urb_pkg::MIN_RING))
            tx_sz_sat = TX_CW'(urb_pkg::MIN_RING);
        else if (tx_sz_req > TX_CW'(TX_DEPTH))
            tx_sz_sat = TX_CW'(TX_DEPTH);
        else
            tx_sz_sat = tx_sz_req;
        tx_sz = TX_LW'(tx_sz_sat);

        rx_head_inc = RX_LW'(rx_head_reg) + RX_LW'(1);
        rx_tail_inc = RX_LW'(rx_tail_reg) + RX_LW'(1);
        tx_head_inc = TX_LW'(tx_head_reg) + TX_LW'(1);
        tx_tail_inc = TX_LW'(tx_tail_reg) + TX_LW'(1);
        rx_nh = (rx_head_inc >= rx_sz) ? '0 : RX_AW'(rx_head_inc);
        rx_nt = (rx_tail_inc >= rx_sz) ? '0 : RX_AW'(rx_tail_inc);
        tx_nh = (tx_head_inc >= tx_sz) ? '0 : TX_AW'(tx_head_inc);
        tx_nt = (tx_tail_inc >= tx_sz) ? '0 : TX_AW'(tx_tail_inc);

        rx_full     = (rx_nh == rx_tail_reg);
        tx_full     = (tx_nh == tx_tail_reg);
        tx_empty    = (tx_head_reg == tx_tail_reg);
        rx_has_data = (rx_level_reg != '0) && (rx_tail_reg != rx_head_reg);

        // level never exceeds size - 1, so no underflow here
        rx_free    = rx_sz - rx_level_reg;
        rx_free_up = rx_free + RX_LW'(1);
        rts_drop   = flow_reg && (RX_CW'(rx_free) <= RX_CW'(thr_reg));
        rts_raise  = flow_reg && !rts_reg && (RX_CW'(rx_free_up) > RX_CW'(thr_reg));
        tx_allowed = !flow_reg || (item_reg.cts && item_reg.dsr);
        dump       = (item_reg.command == urb_pkg::CMD_READ_ERRORS);
        rx_wdata   = item_reg.rx_byte & urb_pkg::char_mask(dws_reg);
    end

    always_comb
    begin
        dws_next      = dws_reg;
        flow_next     = flow_reg;
        thr_next      = thr_reg;
        rx_size_next  = rx_size_reg;
        tx_size_next  = tx_size_reg;
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        rx_level_next = rx_level_reg;
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        rts_next      = rts_reg;
        tbre_next     = tbre_reg;
        msr_next      = msr_reg;
        err_cnt_next  = err_cnt_reg;
        k_next        = k_reg;
        rx_valid_next = rx_valid_reg;
        tx_valid_next = tx_valid_reg;
        wa_next       = wa_reg;
        rx_we         = 1'b0;
        tx_we         = 1'b0;

        if (cfg_we)
        begin
            unique case (urb_pkg::urb_reg_t'(cfg_index))
                urb_pkg::REG_DATA_WIDTH_SEL:    dws_next  = cfg_data[1:0];
                urb_pkg::REG_FLOW_ENABLE:       flow_next = cfg_data[0];
                urb_pkg::REG_RTS_OFF_THRESHOLD: thr_next  = cfg_data;
                urb_pkg::REG_RX_RING_SIZE:
                begin
                    rx_size_next  = cfg_data;
                    rx_head_next  = '0;
                    rx_tail_next  = '0;
                    rx_level_next = '0;
                end
                urb_pkg::REG_TX_RING_SIZE:
                begin
                    tx_size_next = cfg_data;
                    tx_head_next = '0;
                    tx_tail_next = '0;
                end
                default: ;
            endcase
        end

        if (ctrl_cmd.exec)
        begin
            rx_valid_next = 1'b0;
            tx_valid_next = 1'b0;
            wa_next       = 1'b0;
            k_next        = '0;
            unique case (urb_pkg::urb_cmd_t'(item_reg.command))
                urb_pkg::CMD_UART_EVENT:
                begin
                    if (item_reg.line_status[urb_pkg::LS_OVERRUN])
                        err_cnt_next[urb_pkg::ERR_OVERRUN] =
                            err_cnt_reg[urb_pkg::ERR_OVERRUN] + EW'(1);
                    if (item_reg.line_status[urb_pkg::LS_PARITY])
                        err_cnt_next[urb_pkg::ERR_PARITY] =
                            err_cnt_reg[urb_pkg::ERR_PARITY] + EW'(1);
                    if (item_reg.line_status[urb_pkg::LS_FRAMING])
                        err_cnt_next[urb_pkg::ERR_FRAMING] =
                            err_cnt_reg[urb_pkg::ERR_FRAMING] + EW'(1);
                    if (item_reg.line_status[urb_pkg::LS_RX_READY])
                    begin
                        // RTS check uses free space before the store
                        if (rts_drop)
                            rts_next = 1'b0;
                        if (!rx_full)
                        begin
                            rx_we         = 1'b1;
                            rx_head_next  = rx_nh;
                            rx_level_next = rx_level_reg + RX_LW'(1);
                        end
                        else
                        begin
                            err_cnt_next[urb_pkg::ERR_MISSED] =
                                err_cnt_reg[urb_pkg::ERR_MISSED] + EW'(1);
                        end
                    end
                    if (tx_allowed)
                    begin
                        msr_next  = 1'b0;
                        tbre_next = !tx_empty;
                        if (!tx_empty && item_reg.line_status[urb_pkg::LS_TX_READY])
                        begin
                            tx_valid_next = 1'b1;
                            tx_tail_next  = tx_nt;
                        end
                    end
                    else
                    begin
                        msr_next  = 1'b1;
                        tbre_next = 1'b0;
                    end
                end
                urb_pkg::CMD_HOST_WRITE:
                begin
                    if (!tx_full)
                    begin
                        tx_we        = 1'b1;
                        tx_head_next = tx_nh;
                        wa_next      = 1'b1;
                    end
                    if (!tbre_reg && !msr_reg)
                        tbre_next = 1'b1;
                end
                urb_pkg::CMD_HOST_READ:
                begin
                    if (rx_has_data)
                    begin
                        rx_valid_next = 1'b1;
                        rx_level_next = rx_level_reg - RX_LW'(1);
                        rx_tail_next  = rx_nt;
                        if (rts_raise)
                            rts_next = 1'b1;
                    end
                end
                urb_pkg::CMD_FLUSH_RX:
                begin
                    rx_head_next  = '0;
                    rx_tail_next  = '0;
                    rx_level_next = '0;
                end
                urb_pkg::CMD_FLUSH_TX:
                begin
                    tx_head_next = '0;
                    tx_tail_next = '0;
                end
                urb_pkg::CMD_READ_ERRORS: ;
                default: ;
            endcase
        end

        // dump clears each counter as its value is handed out
        if (ctrl_cmd.res_taken && dump)
        begin
            err_cnt_next[k_reg] = '0;
            k_next              = k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dws_reg      <= urb_pkg::DWS_RESET;
            flow_reg     <= urb_pkg::FLOW_RESET;
            thr_reg      <= urb_pkg::THR_RESET;
            rx_size_reg  <= urb_pkg::RING_SIZE_RESET;
            tx_size_reg  <= urb_pkg::RING_SIZE_RESET;
            rx_head_reg  <= '0;
            rx_tail_reg  <= '0;
            rx_level_reg <= '0;
            tx_head_reg  <= '0;
            tx_tail_reg  <= '0;
            rts_reg      <= 1'b1;
            tbre_reg     <= 1'b0;
            msr_reg      <= 1'b0;
            for (int i = 0; i < urb_pkg::NUM_ERR; i++)
            begin
                err_cnt_reg[i] <= '0;
            end
            k_reg        <= '0;
            rx_valid_reg <= 1'b0;
            tx_valid_reg <= 1'b0;
            wa_reg       <= 1'b0;
        end
        else
        begin
            dws_reg      <= dws_next;
            flow_reg     <= flow_next;
            thr_reg      <= thr_next;
            rx_size_reg  <= rx_size_next;
            tx_size_reg  <= tx_size_next;
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            rx_level_reg <= rx_level_next;
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            rts_reg      <= rts_next;
            tbre_reg     <= tbre_next;
            msr_reg      <= msr_next;
            err_cnt_reg  <= err_cnt_next;
            k_reg        <= k_next;
            rx_valid_reg <= rx_valid_next;
            tx_valid_reg <= tx_valid_next;
            wa_reg       <= wa_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load)
        begin
            item_reg <= item;
        end
    end

    // one write and one registered read per ring per cycle
    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_head_reg] <= rx_wdata;
        end
        if (ctrl_cmd.exec)
        begin
            rx_rd_reg <= rx_mem[rx_tail_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_mem[tx_head_reg] <= item_reg.host_byte;
        end
        if (ctrl_cmd.exec)
        begin
            tx_rd_reg <= tx_mem[tx_tail_reg];
        end
    end

    always_comb
    begin
        result.rx_data        = rx_valid_reg ? rx_rd_reg : 8'd0;
        result.rx_data_valid  = rx_valid_reg;
        result.tx_data        = tx_valid_reg ? tx_rd_reg : 8'd0;
        result.tx_data_valid  = tx_valid_reg;
        result.write_accepted = wa_reg;
        result.rts_level      = rts_reg;
        result.rx_fill        = 12'(rx_level_reg);
        result.tx_idle        = tx_empty;
        result.irq_enables    = {msr_reg, tbre_reg};
        result.error_kind     = dump ? k_reg : 2'd0;
        result.error_count    = dump ? err_cnt_reg[k_reg] : '0;
        result.last           = !dump || (k_reg == urb_pkg::ERR_MISSED);
        ctrl_sts.last_res     = result.last;
    end

endmodule

// ===== rtl/uart_ring_buffers_rts_cts_flow.sv =====
`timescale 1ns / 1ps
// Channel    Dir  Handshake     Contents
// item_ch    in   valid/ready   command, line_status, rx_byte, cts, dsr, host_byte
// result_ch  out  valid/ready   ring data, status, error dump, last
// cfg_ch     in   valid/ready   register index, write data (always ready)
//
// One item at a time: accept, execute (ring write and registered ring read),
// then the result. Read errors gives four results, one per counter.
// Reset clears pointers, counters and flags at once; ring stores are not cleared.
// A stalled result holds; no item is taken until its last result is taken.

`include "uart_ring_buffers_rts_cts_flow_defines.svh"

module uart_ring_buffers_rts_cts_flow #(
    parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = urb_pkg::TX_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    urb_item_if.sink      item_ch,
    urb_result_if.source  result_ch,
    urb_cfg_if.sink       cfg_ch
);

    urb_pkg::urb_ctrl_cmd_t ctrl_cmd;
    urb_pkg::urb_ctrl_sts_t ctrl_sts;
    urb_pkg::urb_item_t     item;
    urb_pkg::urb_result_t   result;
    logic                   cfg_we;

    assign cfg_ch.ready = 1'b1;
    assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

    always_comb
    begin
        item.command     = item_ch.command;
        item.line_status = item_ch.line_status;
        item.rx_byte     = item_ch.rx_byte;
        item.cts         = item_ch.cts;
        item.dsr         = item_ch.dsr;
        item.host_byte   = item_ch.host_byte;
    end

    urb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_ch.valid),
        .in_ready  (item_ch.ready),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .ctrl_sts  (ctrl_sts),
        .ctrl_cmd  (ctrl_cmd)
    );

    urb_datapath #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_cmd  (ctrl_cmd),
        .ctrl_sts  (ctrl_sts),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_ch.index),
        .cfg_data  (cfg_ch.data),
        .result    (result)
    );

    always_comb
    begin
        result_ch.rx_data        = result.rx_data;
        result_ch.rx_data_valid  = result.rx_data_valid;
        result_ch.tx_data        = result.tx_data;
        result_ch.tx_data_valid  = result.tx_data_valid;
        result_ch.write_accepted = result.write_accepted;
        result_ch.rts_level      = result.rts_level;
        result_ch.rx_fill        = result.rx_fill;
        result_ch.tx_idle        = result.tx_idle;
        result_ch.irq_enables    = result.irq_enables;
        result_ch.error_kind     = result.error_kind;
        result_ch.error_count    = result.error_count;
        result_ch.last           = result.last;
    end

    `URB_ASSERT(a_no_overlap, !(result_ch.valid && item_ch.ready))
    `URB_ASSERT(a_result_two_after_accept, (item_ch.valid && item_ch.ready) |-> ##2 result_ch.valid)
    `URB_ASSERT_NEXT(a_ready_after_last, result_ch.valid && result_ch.ready && result_ch.last, item_ch.ready)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import urb_pkg::*;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam logic [7:0] M_RX_RDY = 8'h01 << LS_RX_READY;
    localparam logic [7:0] M_OVR    = 8'h01 << LS_OVERRUN;
    localparam logic [7:0] M_PAR    = 8'h01 << LS_PARITY;
    localparam logic [7:0] M_FRM    = 8'h01 << LS_FRAMING;
    localparam logic [7:0] M_TX_RDY = 8'h01 << LS_TX_READY;
    localparam logic [7:0] M_ERRS   = M_OVR | M_PAR | M_FRM;

    typedef struct {
        urb_reg_t    idx;
        logic [11:0] val;
    } reg_write_t;

    logic clk;
    logic rst_n;

    urb_item_if   item_if ();
    urb_result_if result_if ();
    urb_cfg_if    cfg_if ();

    uart_ring_buffers_rts_cts_flow DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_if),
        .result_ch (result_if),
        .cfg_ch    (cfg_if)
    );

    // engine state as seen from outside
    logic [1:0]  cfg_dws;
    logic        cfg_flow;
    logic [11:0] cfg_thr;
    logic [11:0] cfg_rx_size;
    logic [11:0] cfg_tx_size;
    logic [7:0]  rx_mem [RX_DEPTH_DEF];
    logic [7:0]  tx_mem [TX_DEPTH_DEF];
    int unsigned rx_wr, rx_rd, rx_cnt, tx_wr, tx_rd;
    logic        rts_on, tbre_en, msr_en;
    logic [31:0] err_tally [NUM_ERR];

    urb_result_t engine_out_q [$];
    reg_write_t  reg_writes [$];
    int          mismatches;
    bit          idling;
    int          stall_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb failed");
        $finish;
    end

    function automatic int unsigned ring_len(logic [11:0] reg_val, int unsigned depth);
        if (reg_val < MIN_RING)
            return MIN_RING;
        if (reg_val > depth)
            return depth;
        return reg_val;
    endfunction

    function automatic int unsigned advance(int unsigned i, int unsigned size);
        return (i + 1 >= size) ? 0 : i + 1;
    endfunction

    function automatic int unsigned rx_space(int unsigned size);
        return (rx_cnt >= size) ? 0 : size - rx_cnt;
    endfunction

    function automatic void reset_engine();
        cfg_dws     = DWS_RESET;
        cfg_flow    = FLOW_RESET;
        cfg_thr     = THR_RESET;
        cfg_rx_size = RING_SIZE_RESET;
        cfg_tx_size = RING_SIZE_RESET;
        rx_wr = 0;
        rx_rd = 0;
        rx_cnt = 0;
        tx_wr = 0;
        tx_rd = 0;
        rts_on  = 1'b1;
        tbre_en = 1'b0;
        msr_en  = 1'b0;
        for (int k = 0; k < NUM_ERR; k++)
            err_tally[k] = '0;
    endfunction

    function automatic void apply_reg(urb_reg_t idx, logic [11:0] val);
        case (idx)
            REG_DATA_WIDTH_SEL:    cfg_dws = val[1:0];
            REG_FLOW_ENABLE:       cfg_flow = val[0];
            REG_RTS_OFF_THRESHOLD: cfg_thr = val;
            REG_RX_RING_SIZE:
            begin
                cfg_rx_size = val;
                rx_wr = 0;
                rx_rd = 0;
                rx_cnt = 0;
            end
            REG_TX_RING_SIZE:
            begin
                cfg_tx_size = val;
                tx_wr = 0;
                tx_rd = 0;
            end
            default: ;
        endcase
    endfunction

    // Runs one transaction through the engine state and queues what it must produce.
    function automatic void run_ring_engine(urb_item_t it);
        urb_result_t r;
        int unsigned rxsz, txsz, nxt;
        logic [31:0] saved [NUM_ERR];
        r = '0;
        rxsz = ring_len(cfg_rx_size, RX_DEPTH_DEF);
        txsz = ring_len(cfg_tx_size, TX_DEPTH_DEF);
        case (it.command)
            CMD_UART_EVENT:
            begin
                if (it.line_status[LS_OVERRUN])
                    err_tally[ERR_OVERRUN]++;
                if (it.line_status[LS_PARITY])
                    err_tally[ERR_PARITY]++;
                if (it.line_status[LS_FRAMING])
                    err_tally[ERR_FRAMING]++;
                if (it.line_status[LS_RX_READY])
                begin
                    nxt = advance(rx_wr, rxsz);
                    // RTS decision uses the space before this byte lands
                    if (cfg_flow && rx_space(rxsz) <= cfg_thr)
                        rts_on = 1'b0;
                    if (nxt != rx_rd)
                    begin
                        rx_mem[rx_wr] = it.rx_byte & (8'hFF >> (2'd3 - cfg_dws));
                        rx_wr = nxt;
                        rx_cnt++;
                    end
                    else
                        err_tally[ERR_MISSED]++;
                end
                if (!cfg_flow || (it.cts && it.dsr))
                begin
                    if (tx_rd != tx_wr)
                    begin
                        if (it.line_status[LS_TX_READY])
                        begin
                            r.tx_data = tx_mem[tx_rd];
                            r.tx_data_valid = 1'b1;
                            tx_rd = advance(tx_rd, txsz);
                        end
                        tbre_en = 1'b1;
                    end
                    else
                        tbre_en = 1'b0;
                    msr_en = 1'b0;
                end
                else
                begin
                    msr_en = 1'b1;
                    tbre_en = 1'b0;
                end
            end
            CMD_HOST_WRITE:
            begin
                nxt = advance(tx_wr, txsz);
                if (nxt != tx_rd)
                begin
                    tx_mem[tx_wr] = it.host_byte;
                    tx_wr = nxt;
                    r.write_accepted = 1'b1;
                end
                if (!tbre_en && !msr_en)
                    tbre_en = 1'b1;
            end
            CMD_HOST_READ:
            begin
                if (rx_cnt > 0 && rx_rd != rx_wr)
                begin
                    r.rx_data = rx_mem[rx_rd];
                    r.rx_data_valid = 1'b1;
                    rx_cnt--;
                    rx_rd = advance(rx_rd, rxsz);
                    if (cfg_flow && !rts_on && rx_space(rxsz) > cfg_thr)
                        rts_on = 1'b1;
                end
            end
            CMD_FLUSH_RX:
            begin
                rx_wr = 0;
                rx_rd = 0;
                rx_cnt = 0;
            end
            CMD_FLUSH_TX:
            begin
                tx_wr = 0;
                tx_rd = 0;
            end
            default: ;
        endcase
        r.rts_level   = rts_on;
        r.rx_fill     = rx_cnt[11:0];
        r.tx_idle     = (tx_wr == tx_rd);
        r.irq_enables = {msr_en, tbre_en};
        if (it.command == CMD_READ_ERRORS)
        begin
            saved = err_tally;
            for (int k = 0; k < NUM_ERR; k++)
            begin
                err_tally[k] = '0;
                r.error_kind  = 2'(k);
                r.error_count = saved[k];
                r.last        = (k == NUM_ERR - 1);
                engine_out_q.push_back(r);
            end
        end
        else
        begin
            r.last = 1'b1;
            engine_out_q.push_back(r);
        end
    endfunction

    function automatic urb_item_t build_item(logic [2:0] cmd, logic [7:0] ls, logic [7:0] rxb,
                                             logic cts, logic dsr, logic [7:0] hb);
        urb_item_t it;
        it.command     = cmd;
        it.line_status = ls;
        it.rx_byte     = rxb;
        it.cts         = cts;
        it.dsr         = dsr;
        it.host_byte   = hb;
        return it;
    endfunction

    function automatic urb_item_t random_item();
        urb_item_t it;
        int unsigned pick;
        it = build_item(CMD_UART_EVENT, 8'($urandom), 8'($urandom),
                        $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, 8'($urandom));
        it.line_status[LS_RX_READY] = $urandom_range(0, 3) != 0;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.command = CMD_UART_EVENT;
        else if (pick < 62)
            it.command = CMD_HOST_WRITE;
        else if (pick < 84)
            it.command = CMD_HOST_READ;
        else if (pick < 88)
            it.command = CMD_FLUSH_RX;
        else if (pick < 91)
            it.command = CMD_FLUSH_TX;
        else if (pick < 97)
            it.command = CMD_READ_ERRORS;
        else if (pick < 99)
            it.command = CMD_SPARE_6;
        else
            it.command = CMD_SPARE_7;
        return it;
    endfunction

    // valid stays high on return so a following transaction can go out back to back
    task automatic send_item(input urb_item_t it);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item_if.valid       <= 1'b1;
        item_if.command     <= it.command;
        item_if.line_status <= it.line_status;
        item_if.rx_byte     <= it.rx_byte;
        item_if.cts         <= it.cts;
        item_if.dsr         <= it.dsr;
        item_if.host_byte   <= it.host_byte;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        run_ring_engine(it);
    endtask

    task automatic wait_drain();
        item_if.valid <= 1'b0;
        while (engine_out_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void add_reg(urb_reg_t idx, logic [11:0] val);
        reg_write_t w;
        w.idx = idx;
        w.val = val;
        reg_writes.push_back(w);
    endfunction

    task automatic commit_regs();
        reg_write_t w;
        wait_drain();
        while (reg_writes.size() != 0)
        begin
            w = reg_writes.pop_front();
            cfg_if.valid <= 1'b1;
            cfg_if.index <= w.idx;
            cfg_if.data  <= w.val;
            @(posedge clk);
            while (!cfg_if.ready)
                @(posedge clk);
            apply_reg(w.idx, w.val);
        end
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        urb_result_t want;
        if (engine_out_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual rx_data %0h tx_data %0h last %0b",
                     $time, result_if.rx_data, result_if.tx_data, result_if.last);
            mismatches++;
        end
        else
        begin
            want = engine_out_q.pop_front();
            cmp_field("rx_data", want.rx_data, result_if.rx_data);
            cmp_field("rx_data_valid", want.rx_data_valid, result_if.rx_data_valid);
            cmp_field("tx_data", want.tx_data, result_if.tx_data);
            cmp_field("tx_data_valid", want.tx_data_valid, result_if.tx_data_valid);
            cmp_field("write_accepted", want.write_accepted, result_if.write_accepted);
            cmp_field("rts_level", want.rts_level, result_if.rts_level);
            cmp_field("rx_fill", want.rx_fill, result_if.rx_fill);
            cmp_field("tx_idle", want.tx_idle, result_if.tx_idle);
            cmp_field("irq_enables", want.irq_enables, result_if.irq_enables);
            cmp_field("error_kind", want.error_kind, result_if.error_kind);
            cmp_field("error_count", want.error_count, result_if.error_count);
            cmp_field("last", want.last, result_if.last);
        end
    endfunction

    // result side: check each transaction, stall in bursts
    initial
    begin
        result_if.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (result_if.valid && result_if.ready)
                    check_result();
                if (stall_left != 0)
                begin
                    stall_left--;
                    result_if.ready <= 1'b0;
                end
                else if (idling && $urandom_range(0, 5) == 0)
                begin
                    stall_left = $urandom_range(0, 17);
                    result_if.ready <= 1'b0;
                end
                else
                    result_if.ready <= 1'b1;
            end
        end
    end

    task automatic test_directed_basics();
        send_item(build_item(CMD_UART_EVENT, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00));
        send_item(build_item(CMD_HOST_READ, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        send_item(build_item(CMD_HOST_WRITE, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        send_item(build_item(CMD_HOST_WRITE, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
        send_item(build_item(CMD_UART_EVENT, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
        // modem lines hold off the transmitter
        send_item(build_item(CMD_UART_EVENT, M_TX_RDY, 8'h00, 1'b0, 1'b1, 8'h00));
        send_item(build_item(CMD_UART_EVENT, M_TX_RDY, 8'h00, 1'b1, 1'b0, 8'h00));
        send_item(build_item(CMD_UART_EVENT, M_TX_RDY | M_RX_RDY, 8'h00, 1'b1, 1'b1, 8'h00));
        send_item(build_item(CMD_HOST_READ, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        send_item(build_item(CMD_HOST_READ, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        send_item(build_item(CMD_READ_ERRORS, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        send_item(build_item(CMD_HOST_WRITE, 8'h00, 8'h00, 1'b0, 1'b0, 8'hA5));
        send_item(build_item(CMD_FLUSH_TX, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        send_item(build_item(CMD_UART_EVENT, M_TX_RDY | M_RX_RDY, 8'h5A, 1'b1, 1'b1, 8'h00));
        send_item(build_item(CMD_FLUSH_RX, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        send_item(build_item(CMD_HOST_READ, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        send_item(build_item(CMD_SPARE_6, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
        send_item(build_item(CMD_SPARE_7, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
        send_item(build_item(CMD_READ_ERRORS, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
    endtask

    task automatic test_char_widths();
        for (int w = 0; w < 4; w++)
        begin
            add_reg(REG_DATA_WIDTH_SEL, 12'(w));
            commit_regs();
            send_item(build_item(CMD_UART_EVENT, M_RX_RDY, 8'($urandom) | 8'hE0,
                                 1'b1, 1'b1, 8'h00));
            send_item(build_item(CMD_HOST_READ, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        end
    endtask

    // RTS drops as the ring fills past the threshold and comes back as the host drains it
    task automatic test_flow_control();
        add_reg(REG_FLOW_ENABLE, 12'd1);
        add_reg(REG_RTS_OFF_THRESHOLD, 12'd120);
        add_reg(REG_RX_RING_SIZE, 12'd128);
        commit_regs();
        for (int n = 0; n < 12; n++)
            send_item(build_item(CMD_UART_EVENT, M_RX_RDY | (8'($urandom) & M_ERRS),
                                 8'($urandom), 1'($urandom), 1'($urandom), 8'h00));
        for (int n = 0; n < 3; n++)
            send_item(build_item(CMD_HOST_WRITE, 8'h00, 8'h00, 1'b0, 1'b0, 8'($urandom)));
        for (int c = 0; c < 4; c++)
            send_item(build_item(CMD_UART_EVENT, M_TX_RDY, 8'h00, c[0], c[1], 8'h00));
        add_reg(REG_FLOW_ENABLE, 12'd0);
        commit_regs();
        send_item(build_item(CMD_UART_EVENT, M_TX_RDY, 8'h00, 1'b0, 1'b0, 8'h00));
        send_item(build_item(CMD_HOST_READ, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        send_item(build_item(CMD_UART_EVENT, M_TX_RDY, 8'h00, 1'b0, 1'b0, 8'h00));
        add_reg(REG_FLOW_ENABLE, 12'd1);
        commit_regs();
        for (int n = 0; n < 12; n++)
            send_item(build_item(CMD_HOST_READ, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
        send_item(build_item(CMD_READ_ERRORS, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
    endtask

    task automatic test_random_mix();
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    add_reg(REG_DATA_WIDTH_SEL, 12'd0);
                    add_reg(REG_FLOW_ENABLE, 12'd0);
                    add_reg(REG_RTS_OFF_THRESHOLD, 12'd0);
                    add_reg(REG_RX_RING_SIZE, 12'd0);
                    add_reg(REG_TX_RING_SIZE, 12'hFFF);
                end
                1:
                begin
                    add_reg(REG_DATA_WIDTH_SEL, 12'hFFF);
                    add_reg(REG_FLOW_ENABLE, 12'd1);
                    add_reg(REG_RTS_OFF_THRESHOLD, 12'hFFF);
                    add_reg(REG_RX_RING_SIZE, 12'd128);
                    add_reg(REG_TX_RING_SIZE, 12'd128);
                end
                3:
                begin
                    add_reg(REG_DATA_WIDTH_SEL, 12'($urandom));
                    add_reg(REG_RTS_OFF_THRESHOLD, 12'd2048);
                    add_reg(REG_RX_RING_SIZE, 12'd2048);
                    add_reg(REG_TX_RING_SIZE, 12'd2047);
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                        add_reg(REG_DATA_WIDTH_SEL, 12'($urandom));
                    if ($urandom_range(0, 1))
                        add_reg(REG_FLOW_ENABLE, 12'($urandom));
                    add_reg(REG_RTS_OFF_THRESHOLD, 12'($urandom_range(0, 300)));
                    if ($urandom_range(0, 1))
                        add_reg(REG_RX_RING_SIZE, 12'($urandom));
                    if ($urandom_range(0, 1))
                        add_reg(REG_TX_RING_SIZE, 12'($urandom));
                end
            endcase
            commit_regs();
            idling = (ph != 4);
            for (int n = 0; n < 10; n++)
            begin
                if (ph == 2 && n == 5)
                    wait_drain();
                send_item(random_item());
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        idling = 1'b1;
        mismatches = 0;
        item_if.valid       = 1'b0;
        item_if.command     = CMD_UART_EVENT;
        item_if.line_status = '0;
        item_if.rx_byte     = '0;
        item_if.cts         = 1'b0;
        item_if.dsr         = 1'b0;
        item_if.host_byte   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_DATA_WIDTH_SEL;
        cfg_if.data  = '0;
        reset_engine();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_basics();
        test_char_widths();
        test_flow_control();
        test_random_mix();

        wait_drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/urb_pkg.sv
rtl/urb_item_if.sv
rtl/urb_result_if.sv
rtl/urb_cfg_if.sv
rtl/urb_ctrl.sv
rtl/urb_datapath.sv
rtl/uart_ring_buffers_rts_cts_flow.sv
tb/tb.sv
